// File: sv/escp_pkg.sv
// shared constants and controller/datapath interface types for the second-chance pager
package escp_pkg;

  localparam int FRAMES_DEF     = 8;
  localparam int SWAP_SLOTS_DEF = 16;
  localparam int PAGE_BITS_DEF  = 8;

  localparam int PAGE_ID_W    = 8;
  localparam int FRAME_IDX_W  = 3;
  localparam int SLOT_IDX_W   = 4;
  localparam int CFG_FRAMES_W = 4;
  localparam int CFG_SLOTS_W  = 5;
  localparam int APB_ADDR_W   = 3;
  localparam int APB_DATA_W   = 32;

  localparam logic REG_FRAMES = 1'b0;
  localparam logic REG_SLOTS  = 1'b1;

  localparam logic [CFG_FRAMES_W-1:0] FRAMES_RST = 4'd8;
  localparam logic [CFG_SLOTS_W-1:0]  SLOTS_RST  = 5'd16;

  typedef struct packed {
    logic accept;
    logic hscan;
    logic commit_hit;
    logic vinit;
    logic vstep;
    logic vread;
    logic vcap;
    logic sinit;
    logic so_next;
    logic so_take;
    logic sistep;
    logic si_take;
    logic commit_miss;
  } escp_cmd_t;

  typedef struct packed {
    logic hs_match;
    logic hs_end;
    logic vic_hit;
    logic vic_occ;
    logic so_free;
    logic so_end;
    logic si_match;
    logic si_end;
  } escp_sts_t;

endpackage

// File: sv/escp_ctrl.sv
// sequencing state machine for hit scan, clock sweep and swap slot searches
module escp_ctrl
  import escp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  escp_sts_t sts,
  output escp_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_HSCAN  = 8'b0000_0010,
    ST_VSCAN  = 8'b0000_0100,
    ST_VREAD  = 8'b0000_1000,
    ST_VCAP   = 8'b0001_0000,
    ST_SOSCAN = 8'b0010_0000,
    ST_SISCAN = 8'b0100_0000,
    ST_COMMIT = 8'b1000_0000
  } escp_state_t;

  escp_state_t state_r;
  escp_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_HSCAN;
        end
      end
      ST_HSCAN: begin
        cmd.hscan = 1'b1;
        if (sts.hs_match) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = ST_IDLE;
        end else if (sts.hs_end) begin
          cmd.vinit = 1'b1;
          state_nxt = ST_VSCAN;
        end
      end
      ST_VSCAN: begin
        if (sts.vic_hit) begin
          state_nxt = ST_VREAD;
        end else begin
          cmd.vstep = 1'b1;
        end
      end
      ST_VREAD: begin
        cmd.vread = 1'b1;
        state_nxt = ST_VCAP;
      end
      ST_VCAP: begin
        cmd.vcap  = 1'b1;
        cmd.sinit = 1'b1;
        state_nxt = sts.vic_occ ? ST_SOSCAN : ST_SISCAN;
      end
      ST_SOSCAN: begin
        if (sts.so_free) begin
          cmd.so_take = 1'b1;
          cmd.sinit   = 1'b1;
          state_nxt   = ST_SISCAN;
        end else if (sts.so_end) begin
          cmd.sinit = 1'b1;
          state_nxt = ST_SISCAN;
        end else begin
          cmd.so_next = 1'b1;
        end
      end
      ST_SISCAN: begin
        cmd.sistep = 1'b1;
        if (sts.si_match) begin
          cmd.si_take = 1'b1;
          state_nxt   = ST_COMMIT;
        end else if (sts.si_end) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit_miss = 1'b1;
        state_nxt       = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(cmd.commit_hit || cmd.commit_miss))
    else $error("busy dropped without a commit");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

endmodule

// File: sv/escp_dpath.sv
// frame table, swap slot table, clock hand and result registers
module escp_dpath
  import escp_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int SWAP_SLOTS = SWAP_SLOTS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  escp_cmd_t               cmd,
  output escp_sts_t               sts,
  input  logic [CFG_FRAMES_W-1:0] cfg_frames,
  input  logic [CFG_SLOTS_W-1:0]  cfg_slots,
  input  logic [PAGE_ID_W-1:0]    in_page_id,
  input  logic                    in_is_write,
  output logic                    out_strobe,
  output logic                    out_hit,
  output logic [FRAME_IDX_W-1:0]  out_frame_index,
  output logic                    out_evicted_valid,
  output logic [PAGE_ID_W-1:0]    out_evicted_page,
  output logic                    out_swap_out_valid,
  output logic [SLOT_IDX_W-1:0]   out_swap_out_slot,
  output logic                    out_swap_in_valid,
  output logic [SLOT_IDX_W-1:0]   out_swap_in_slot
);

  localparam int FIW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCW = $clog2(FRAMES + 1);
  localparam int SIW = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
  localparam int SCW = $clog2(SWAP_SLOTS + 1);

  logic [FCW-1:0]       n_act;
  logic [SCW-1:0]       m_act;
  logic [PAGE_BITS-1:0] page_r;
  logic                 wr_r;

  // frame state
  logic [PAGE_BITS-1:0] frame_mem [FRAMES];
  logic [PAGE_BITS-1:0] f_rdata_r;
  logic [FRAMES-1:0]    frame_occ_r;
  logic [FRAMES-1:0]    frame_ref_r;
  logic [FRAMES-1:0]    frame_mod_r;

  // hit scan
  logic [FCW-1:0] ptr_r;
  logic [FIW-1:0] ptr_idx;
  logic [FIW-1:0] pidx_r;
  logic           pend_r;

  // clock sweep
  logic [FIW-1:0] hand_r;
  logic [FIW-1:0] vpos_r;
  logic [FIW-1:0] vpos_nxt;
  logic [FIW-1:0] vstart;
  logic [FCW-1:0] vpos_p1;
  logic [FCW-1:0] vcnt_r;
  logic [FCW-1:0] vcnt_p1;
  logic           want_r;

  // swap slots
  logic [PAGE_BITS-1:0]  slot_mem [SWAP_SLOTS];
  logic [PAGE_BITS-1:0]  s_rdata_r;
  logic [SWAP_SLOTS-1:0] slot_used_r;
  logic [SCW-1:0]        sptr_r;
  logic [SIW-1:0]        sptr_idx;
  logic [SIW-1:0]        sidx_r;
  logic                  spend_r;

  // miss results
  logic [PAGE_BITS-1:0] vic_page_r;
  logic                 vic_occ_r;
  logic                 so_valid_r;
  logic [SIW-1:0]       so_slot_r;
  logic                 si_valid_r;
  logic [SIW-1:0]       si_slot_r;

  always_comb begin
    if (cfg_frames == '0) begin
      n_act = FCW'(1);
    end else if (32'(cfg_frames) > FRAMES) begin
      n_act = FCW'(FRAMES);
    end else begin
      n_act = FCW'(cfg_frames);
    end
    if (cfg_slots == '0) begin
      m_act = SCW'(1);
    end else if (32'(cfg_slots) > SWAP_SLOTS) begin
      m_act = SCW'(SWAP_SLOTS);
    end else begin
      m_act = SCW'(cfg_slots);
    end
  end

  assign ptr_idx  = ptr_r[FIW-1:0];
  assign sptr_idx = sptr_r[SIW-1:0];
  assign vpos_p1  = FCW'(vpos_r) + FCW'(1);
  assign vpos_nxt = (vpos_p1 < n_act) ? FIW'(vpos_p1) : '0;
  assign vstart   = (FCW'(hand_r) < n_act) ? hand_r : '0;
  assign vcnt_p1  = vcnt_r + FCW'(1);

  always_comb begin
    sts.hs_match = pend_r && frame_occ_r[pidx_r] && (f_rdata_r == page_r);
    sts.hs_end   = !pend_r && (ptr_r >= n_act);
    sts.vic_hit  = !(frame_occ_r[vpos_r] && frame_ref_r[vpos_r]) &&
                   ((frame_occ_r[vpos_r] && frame_mod_r[vpos_r]) == want_r);
    sts.vic_occ  = frame_occ_r[vpos_r];
    sts.so_free  = (sptr_r < m_act) && !slot_used_r[sptr_idx];
    sts.so_end   = (sptr_r >= m_act);
    sts.si_match = spend_r && slot_used_r[sidx_r] && (s_rdata_r == page_r);
    sts.si_end   = !spend_r && (sptr_r >= m_act);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      page_r <= PAGE_BITS'(in_page_id);
      wr_r   <= in_is_write;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_miss) begin
      frame_mem[vpos_r] <= page_r;
    end
    f_rdata_r <= frame_mem[cmd.vread ? vpos_r : ptr_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_occ_r <= '0;
      frame_ref_r <= '0;
      frame_mod_r <= '0;
    end else begin
      if (cmd.commit_hit) begin
        frame_ref_r[pidx_r] <= 1'b1;
        if (wr_r) begin
          frame_mod_r[pidx_r] <= 1'b1;
        end
      end
      // second pass of the sweep takes away the second chance
      if (cmd.vstep && want_r) begin
        frame_ref_r[vpos_r] <= 1'b0;
      end
      if (cmd.commit_miss) begin
        frame_occ_r[vpos_r] <= 1'b1;
        frame_ref_r[vpos_r] <= 1'b1;
        frame_mod_r[vpos_r] <= wr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.accept) begin
      ptr_r  <= '0;
      pend_r <= 1'b0;
    end else if (cmd.hscan) begin
      if (ptr_r < n_act) begin
        pend_r <= 1'b1;
        pidx_r <= ptr_idx;
        ptr_r  <= ptr_r + FCW'(1);
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hand_r <= '0;
      vpos_r <= '0;
      vcnt_r <= '0;
      want_r <= 1'b0;
    end else begin
      if (cmd.vinit) begin
        vpos_r <= vstart;
        vcnt_r <= '0;
        want_r <= 1'b0;
      end else if (cmd.vstep) begin
        vpos_r <= vpos_nxt;
        if (vcnt_p1 == n_act) begin
          vcnt_r <= '0;
          want_r <= !want_r;
        end else begin
          vcnt_r <= vcnt_p1;
        end
      end
      if (cmd.commit_miss) begin
        hand_r <= vpos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.so_take) begin
      slot_mem[sptr_idx] <= vic_page_r;
    end
    s_rdata_r <= slot_mem[sptr_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_used_r <= '0;
    end else begin
      if (cmd.so_take) begin
        slot_used_r[sptr_idx] <= 1'b1;
      end
      if (cmd.si_take) begin
        slot_used_r[sidx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sptr_r  <= '0;
      spend_r <= 1'b0;
    end else if (cmd.sinit) begin
      sptr_r  <= '0;
      spend_r <= 1'b0;
    end else if (cmd.so_next) begin
      sptr_r <= sptr_r + SCW'(1);
    end else if (cmd.sistep) begin
      if (sptr_r < m_act) begin
        spend_r <= 1'b1;
        sidx_r  <= sptr_idx;
        sptr_r  <= sptr_r + SCW'(1);
      end else begin
        spend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      so_valid_r <= 1'b0;
      si_valid_r <= 1'b0;
      so_slot_r  <= '0;
      si_slot_r  <= '0;
      vic_occ_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        so_valid_r <= 1'b0;
        si_valid_r <= 1'b0;
        so_slot_r  <= '0;
        si_slot_r  <= '0;
      end
      if (cmd.vcap) begin
        vic_occ_r <= frame_occ_r[vpos_r];
      end
      if (cmd.so_take) begin
        so_valid_r <= 1'b1;
        so_slot_r  <= sptr_idx;
      end
      if (cmd.si_take) begin
        si_valid_r <= 1'b1;
        si_slot_r  <= sidx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vcap) begin
      vic_page_r <= f_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= cmd.commit_hit || cmd.commit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_hit) begin
      out_hit            <= 1'b1;
      out_frame_index    <= FRAME_IDX_W'(pidx_r);
      out_evicted_valid  <= 1'b0;
      out_evicted_page   <= '0;
      out_swap_out_valid <= 1'b0;
      out_swap_out_slot  <= '0;
      out_swap_in_valid  <= 1'b0;
      out_swap_in_slot   <= '0;
    end else if (cmd.commit_miss) begin
      out_hit            <= 1'b0;
      out_frame_index    <= FRAME_IDX_W'(vpos_r);
      out_evicted_valid  <= vic_occ_r;
      out_evicted_page   <= vic_occ_r ? PAGE_ID_W'(vic_page_r) : '0;
      out_swap_out_valid <= so_valid_r;
      out_swap_out_slot  <= SLOT_IDX_W'(so_slot_r);
      out_swap_in_valid  <= si_valid_r;
      out_swap_in_slot   <= SLOT_IDX_W'(si_slot_r);
    end
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_swap_out_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_swap_out_valid) |-> (out_evicted_valid && !out_hit))
    else $error("swap-out without an eviction");

  a_loaded_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_miss |=> (frame_occ_r[$past(vpos_r)] && frame_ref_r[$past(vpos_r)]))
    else $error("loaded frame not marked occupied and referenced");

endmodule

// File: sv/enhanced_second_chance_pager_core.sv
// top level of the enhanced second-chance pager with register port
// One page access is taken at a time: start is accepted while busy is low, and the
// result appears on the out_ ports for exactly one cycle with out_strobe high; the
// receiver cannot stall it, so it must take every result transfer as it comes. The
// hit scan reads the frame table memory one frame per cycle. A fault runs the frame
// scan, the clock sweep, a read of the victim, a search for a free swap slot when the
// victim frame is occupied, a search of swap for the page and the commit. busy drops
// in the strobe cycle, so the next start can be taken there. Registers frames_in_use
// (byte 0) and swap_slots_in_use (byte 4) may be written only while busy is low; zero
// counts as one and larger values saturate at the table sizes.
module enhanced_second_chance_pager_core
  import escp_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int SWAP_SLOTS = SWAP_SLOTS_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [PAGE_ID_W-1:0]   in_page_id,
  input  logic                   in_is_write,
  output logic                   out_strobe,
  output logic                   out_hit,
  output logic [FRAME_IDX_W-1:0] out_frame_index,
  output logic                   out_evicted_valid,
  output logic [PAGE_ID_W-1:0]   out_evicted_page,
  output logic                   out_swap_out_valid,
  output logic [SLOT_IDX_W-1:0]  out_swap_out_slot,
  output logic                   out_swap_in_valid,
  output logic [SLOT_IDX_W-1:0]  out_swap_in_slot,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  logic [CFG_FRAMES_W-1:0] cfg_frames_r;
  logic [CFG_SLOTS_W-1:0]  cfg_slots_r;
  logic                    cfg_wr;
  escp_cmd_t               cmd;
  escp_sts_t               sts;

  // register transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= FRAMES_RST;
      cfg_slots_r  <= SLOTS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FRAMES) begin
        cfg_frames_r <= pwdata[CFG_FRAMES_W-1:0];
      end else begin
        cfg_slots_r <= pwdata[CFG_SLOTS_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SLOTS) ? APB_DATA_W'(cfg_slots_r)
                                          : APB_DATA_W'(cfg_frames_r);

  escp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  escp_dpath #(
    .FRAMES     (FRAMES),
    .SWAP_SLOTS (SWAP_SLOTS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_frames         (cfg_frames_r),
    .cfg_slots          (cfg_slots_r),
    .in_page_id         (in_page_id),
    .in_is_write        (in_is_write),
    .out_strobe         (out_strobe),
    .out_hit            (out_hit),
    .out_frame_index    (out_frame_index),
    .out_evicted_valid  (out_evicted_valid),
    .out_evicted_page   (out_evicted_page),
    .out_swap_out_valid (out_swap_out_valid),
    .out_swap_out_slot  (out_swap_out_slot),
    .out_swap_in_valid  (out_swap_in_valid),
    .out_swap_in_slot   (out_swap_in_slot)
  );

endmodule
